FILE: design/longest_common_subsequence_top_defines.svh
// Assertion macros for the longest common subsequence block.
`ifndef LONGEST_COMMON_SUBSEQUENCE_TOP_DEFINES_SVH
`define LONGEST_COMMON_SUBSEQUENCE_TOP_DEFINES_SVH
// Property that must hold at every clock edge outside reset.
`define LCS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: design/lcs_pkg.sv
// Shared types, constants and codes for the longest common subsequence block.
package lcs_pkg;
    localparam int MaxLen  = 64;
    localparam int IdxW    = $clog2(MaxLen);
    localparam int CntW    = $clog2(MaxLen + 1);

    localparam logic [1:0] FUNC_LOAD_A = 2'd0;
    localparam logic [1:0] FUNC_LOAD_B = 2'd1;
    localparam logic [1:0] FUNC_RUN    = 2'd2;

    localparam logic [1:0] DIR_DIAG = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;
    localparam logic [1:0] DIR_LEFT = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] symbol;
    } t_in;

    typedef struct packed {
        logic [7:0] out_symbol;
        logic [6:0] seq_length;
        logic       is_last;
        logic       is_empty;
        logic       overflowed;
    } t_out;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_a;
        logic load_b;
        logic fill_init;   // reset indices to the first cell
        logic fill_rd;     // read score row and second string for one cell
        logic fill_step;   // evaluate one cell
        logic trace_init;  // set i,j to the counts
        logic trace_rd;    // issue direction/string read
        logic trace_step;  // act on read data
        logic emit;        // show one result
        logic clear;       // clear counts and drop flag
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic fill_done;   // last cell evaluated this cycle
        logic trace_done;  // i or j reached zero
        logic emit_last;   // this emit is the final one
        logic empty;       // either count is zero
    } t_sts;
endpackage

FILE: design/lcs_datapath.sv
// Datapath: string stores, score rows, direction table, answer buffer.
module lcs_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lcs_pkg::t_in  i_item,
    input  lcs_pkg::t_cmd i_cmd,
    output lcs_pkg::t_sts o_sts,
    output lcs_pkg::t_out o_result
);
    import lcs_pkg::*;

    logic [7:0] r_str_a [MaxLen];
    logic [7:0] r_str_b [MaxLen];
    logic [1:0] r_dir   [MaxLen*MaxLen];
    logic [7:0] r_ans   [MaxLen];
    logic [CntW-1:0] r_prev [MaxLen];  // previous score row, entry j-1 holds column j
    logic [CntW-1:0] r_cnt_a, r_cnt_b, r_i, r_j, r_len, r_k;
    logic [CntW-1:0] r_left, r_diag, r_up_q;
    logic            r_drop;
    logic [1:0]      r_dir_q;
    logic [7:0]      r_sym_a_q, r_ans_q, r_b_q;
    logic [7:0]      r_a_sym;  // current row symbol

    // Fill: i walks rows 1..cnt_a, j walks 1..cnt_b; each cell is a registered
    // read, then an evaluate.
    logic [CntW-1:0] up_s, cell_s, rd_k;
    logic [1:0]      code_s;
    logic            match_s;
    logic [IdxW-1:0] im1, jm1;

    assign im1 = IdxW'(r_i - 1'b1);
    assign jm1 = IdxW'(r_j - 1'b1);

    always_comb begin
        up_s    = (r_i == CntW'(1)) ? '0 : r_up_q;  // row 1 sits under the zero row
        match_s = (r_a_sym == r_b_q);
        if (match_s) begin
            cell_s = r_diag + 1'b1;
            code_s = DIR_DIAG;
        end else if (up_s >= r_left) begin
            cell_s = up_s;
            code_s = DIR_UP;
        end else begin
            cell_s = r_left;
            code_s = DIR_LEFT;
        end
    end

    // Answer read address runs one emit ahead.
    assign rd_k = r_k + CntW'(i_cmd.emit);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_a && r_cnt_a < CntW'(MaxLen)) r_str_a[r_cnt_a[IdxW-1:0]] <= i_item.symbol;
        if (i_cmd.load_b && r_cnt_b < CntW'(MaxLen)) r_str_b[r_cnt_b[IdxW-1:0]] <= i_item.symbol;
        if (i_cmd.fill_rd) begin
            r_up_q <= r_prev[jm1];
            r_b_q  <= r_str_b[jm1];
        end
        if (i_cmd.fill_step) begin
            r_dir[{im1, jm1}] <= code_s;
            r_prev[jm1]       <= cell_s;
        end
        if (i_cmd.trace_rd) begin
            r_dir_q   <= r_dir[{im1, jm1}];
            r_sym_a_q <= r_str_a[im1];
        end
        if (i_cmd.trace_step && r_dir_q == DIR_DIAG) r_ans[IdxW'(r_len)] <= r_sym_a_q;
        r_ans_q <= r_ans[IdxW'(r_len - rd_k - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_drop  <= 1'b0;
            r_i <= '0;
            r_j <= '0;
            r_len <= '0;
            r_k <= '0;
        end else begin
            if (i_cmd.load_a) begin
                if (r_cnt_a < CntW'(MaxLen)) r_cnt_a <= r_cnt_a + 1'b1;
                else r_drop <= 1'b1;
            end
            if (i_cmd.load_b) begin
                if (r_cnt_b < CntW'(MaxLen)) r_cnt_b <= r_cnt_b + 1'b1;
                else r_drop <= 1'b1;
            end
            if (i_cmd.trace_init) begin
                r_i <= r_cnt_a;
                r_j <= r_cnt_b;
                r_len <= '0;
                r_k <= '0;
            end else if (i_cmd.fill_init) begin
                r_i <= CntW'(1);
                r_j <= CntW'(1);
                r_left <= '0;
                r_diag <= '0;
                r_a_sym <= r_str_a[0];
            end else if (i_cmd.fill_step) begin
                if (r_j == r_cnt_b) begin
                    r_i <= r_i + 1'b1;
                    r_j <= CntW'(1);
                    r_left <= '0;
                    r_diag <= '0;
                    r_a_sym <= r_str_a[IdxW'(r_i)];
                end else begin
                    r_j <= r_j + 1'b1;
                    r_left <= cell_s;
                    r_diag <= up_s;
                end
            end else if (i_cmd.trace_step) begin
                unique case (r_dir_q)
                    DIR_DIAG: begin
                        r_i <= r_i - 1'b1;
                        r_j <= r_j - 1'b1;
                        r_len <= r_len + 1'b1;
                    end
                    DIR_UP:  r_i <= r_i - 1'b1;
                    default: r_j <= r_j - 1'b1;
                endcase
            end else if (i_cmd.emit) begin
                r_k <= r_k + 1'b1;
            end
            if (i_cmd.clear) begin
                r_cnt_a <= '0;
                r_cnt_b <= '0;
                r_drop  <= 1'b0;
            end
        end
    end

    assign o_sts.fill_done  = (r_i == r_cnt_a) && (r_j == r_cnt_b);
    assign o_sts.trace_done = (r_i == '0) || (r_j == '0);
    assign o_sts.emit_last  = (r_k + 1'b1 >= r_len);
    assign o_sts.empty      = (r_cnt_a == '0) || (r_cnt_b == '0);

    // Answer stored reversed; read data registered, k is issued one emit ahead.
    assign o_result.out_symbol = (r_len == '0) ? 8'd0 : r_ans_q;
    assign o_result.seq_length = 7'(r_len);
    assign o_result.is_last    = 1'b1;
    assign o_result.is_empty   = (r_len == '0);
    assign o_result.overflowed = r_drop;
endmodule

FILE: design/lcs_ctrl.sv
// Controller state machine sequencing load, fill, trace back and emission.
module lcs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_func,
    input  lcs_pkg::t_sts i_sts,
    output lcs_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_strobe,
    output logic          o_last
);
    import lcs_pkg::*;
    `include "longest_common_subsequence_top_defines.svh"

    localparam logic [2:0] S_IDLE = 3'd0, S_FILL = 3'd1, S_TRD = 3'd2, S_TST = 3'd3,
                           S_PRE = 3'd4, S_EMIT = 3'd5, S_FRD = 3'd6;
    logic [2:0] r_state, n_state;
    logic       r_strobe, n_strobe, r_last, n_last;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        n_strobe = 1'b0;
        n_last   = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_start) begin
                o_cmd.load_a = (i_func == FUNC_LOAD_A);
                o_cmd.load_b = (i_func == FUNC_LOAD_B);
                if (i_func == FUNC_RUN) begin
                    if (i_sts.empty) begin
                        o_cmd.trace_init = 1'b1;
                        n_state = S_TRD;
                    end else begin
                        o_cmd.fill_init = 1'b1;
                        n_state = S_FRD;
                    end
                end
            end
            S_FRD: begin
                o_cmd.fill_rd = 1'b1;
                n_state = S_FILL;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_sts.fill_done) begin
                    o_cmd.trace_init = 1'b1;
                    n_state = S_TRD;
                end else begin
                    n_state = S_FRD;
                end
            end
            S_TRD: begin
                if (i_sts.trace_done) n_state = S_PRE;
                else begin
                    o_cmd.trace_rd = 1'b1;
                    n_state = S_TST;
                end
            end
            S_TST: begin
                o_cmd.trace_step = 1'b1;
                n_state = S_TRD;
            end
            S_PRE: n_state = S_EMIT;  // first answer read in flight
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_strobe   = 1'b1;
                n_last     = i_sts.emit_last;
                if (i_sts.emit_last) begin
                    o_cmd.clear = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_last   = r_last;

    `LCS_ASSERT(a_idle_no_strobe_twice, i_clk, i_rst_n, !(r_last && n_strobe && r_state == S_IDLE),
        "strobe after last")
    `LCS_ASSERT_NEXT(a_emit_strobe, i_clk, i_rst_n, r_state == S_EMIT, r_strobe,
        "emit without strobe")
    `LCS_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n, r_state == S_EMIT && i_sts.emit_last,
        r_state == S_IDLE && r_last, "last did not end run")
endmodule

FILE: design/longest_common_subsequence_top.sv
// Top level of the longest common subsequence engine.
// Loads with func 0/1 keep busy low. A compute (func 2) raises busy after its
// accepting edge. With A and B the string lengths (each capped at 64), the
// table fill evaluates each of the A*B cells as a registered read of the score
// row and second string, then an evaluate; it is skipped when a string is
// empty. The trace back takes at most A+B-1 steps, each a direction-table
// read, then an act on the read data; a further state sees it end and another
// prefetches the first answer symbol. Then comes one emit per subsequence
// symbol (one when empty); each result transaction shows on the ports in the
// cycle after its emit, and the final one shows in the first cycle with busy
// low again. The receiver cannot stall: every o_valid cycle is a transaction.
// An empty subsequence yields one transaction with is_empty set. Counts and
// the overflow flag clear when the final transaction is emitted.
module longest_common_subsequence_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  lcs_pkg::t_in  i_item,
    output logic          o_valid,
    output lcs_pkg::t_out o_result
);
    import lcs_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_out dp_res;
    logic last;
    t_out r_res;

    lcs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_func(i_item.func),
        .i_sts(sts), .o_cmd(cmd), .o_busy(busy), .o_strobe(o_valid), .o_last(last)
    );

    lcs_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_item), .i_cmd(cmd),
        .o_sts(sts), .o_result(dp_res)
    );

    // Capture the result fields with the strobe.
    always_ff @(posedge i_clk) begin
        if (cmd.emit) r_res <= dp_res;
    end

    always_comb begin
        o_result = r_res;
        o_result.is_last = last;
    end
endmodule
